// ----- rtl/pcg_pkg.sv -----
// Package for the PCG32 random generator unit: types, codes and constants.
// Shared by the controller, the datapath, the divider, the top level and the checker.
// Depends on nothing.
`default_nettype none

package pcg_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned STATE_W = 64;
  localparam int unsigned DIV_CNT_W = $clog2(DATA_W);
  localparam int unsigned WARMUP_STEPS_DEF = 10;

  localparam logic [DATA_W-1:0] LCG_MUL_LO = 32'h4C95_7F2D;
  localparam logic [DATA_W-1:0] LCG_MUL_HI = 32'h5851_F42D;
  localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};

  typedef enum logic [1:0] {
    OP_RESEED = 2'd0,
    OP_RAW    = 2'd1,
    OP_RANGED = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_SEEDED = 2'd1,
    ST_BAD_RANGE  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    MUL_IDLE,
    MUL_LO,
    MUL_X1,
    MUL_X2
  } mul_ph_e;

  typedef enum logic {
    DIV_LIMIT,
    DIV_DRAW
  } div_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_STEP_LO,
    S_STEP_X1,
    S_STEP_X2,
    S_ADD_SEED,
    S_LIMIT_DIV,
    S_MOD_DIV,
    S_DONE
  } fsm_e;

  typedef struct packed {
    logic     accept;
    logic     clr_state;
    logic     add_seed;
    mul_ph_e  mul_ph;
    logic     div_start;
    div_sel_e div_sel;
    logic     load_limit;
    logic     load_result;
    status_e  res_status;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic range_bad;
    logic span_zero;
    logic reject;
    logic div_done;
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/pcg_div.sv -----
// Iterative 32-bit remainder unit, one quotient bit per cycle.
// Uses pcg_pkg for widths.
`default_nettype none

module pcg_div
  import pcg_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DATA_W-1:0] dividend_i,
  input  wire logic [DATA_W-1:0] divisor_i,
  output logic                   done_o,
  output logic [DATA_W-1:0]      rem_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DATA_W-1:0]    rem_q, rem_d;
  logic [DATA_W-1:0]    dvd_q, dvd_d;
  logic [DATA_W:0]      trial;
  logic [DATA_W:0]      diff;

  assign trial = {rem_q, dvd_q[DATA_W-1]};
  assign diff  = trial - {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvd_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = diff[DATA_W] ? trial[DATA_W-1:0] : diff[DATA_W-1:0];
      dvd_d = {dvd_q[DATA_W-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DATA_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ----- rtl/pcg_dp.sv -----
// Datapath of the PCG32 generator: seed and state registers, shared 32x32 multiplier,
// output permutation, range logic and result registers. Uses pcg_pkg and pcg_div.
`default_nettype none

module pcg_dp
  import pcg_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire cmd_t                  cmd_i,
  output sts_t                       sts_o,
  input  wire logic [2*DATA_W-1:0]   in_data_i,
  input  wire logic [1:0]            in_user_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [STATE_W-1:0]    cfg_data_i,
  output logic      [2*DATA_W-1:0]   out_data_o,
  output logic      [1:0]            out_user_o
);

  logic [STATE_W-1:0]  seed_q;
  logic [STATE_W-1:0]  state_q, state_d;
  logic [STATE_W-1:0]  acc_q, acc_d;
  logic [DATA_W-1:0]   draw_q, draw_d;
  logic [DATA_W-1:0]   lo_q, hi_q;
  op_e                 op_q;
  logic [DATA_W-1:0]   limit_q;
  logic [DATA_W-1:0]   raw_q, ranged_q;
  status_e             status_q;

  logic [DATA_W-1:0]   mul_a, mul_b;
  logic [STATE_W-1:0]  product;
  logic [STATE_W-1:0]  mixed;
  logic [DATA_W-1:0]   xs;
  logic [4:0]          rot;
  logic [2*DATA_W-1:0] xs_twice;
  logic [DATA_W-1:0]   perm;
  logic [DATA_W-1:0]   span;
  logic                span_zero;
  logic [DATA_W-1:0]   div_dividend;
  logic                div_done;
  logic [DATA_W-1:0]   div_rem;
  logic [DATA_W-1:0]   offset;
  logic [DATA_W-1:0]   raw_d, ranged_d;

  // The permuted word is taken from the state before the step.
  assign mixed    = state_q ^ (state_q >> 18);
  assign xs       = mixed[58:27];
  assign rot      = state_q[63:59];
  assign xs_twice = {xs, xs} >> rot;
  assign perm     = xs_twice[DATA_W-1:0];

  always_comb begin
    unique case (cmd_i.mul_ph)
      MUL_X1: begin
        mul_a = state_q[STATE_W-1:DATA_W];
        mul_b = LCG_MUL_LO;
      end
      MUL_X2: begin
        mul_a = state_q[DATA_W-1:0];
        mul_b = LCG_MUL_HI;
      end
      default: begin
        mul_a = state_q[DATA_W-1:0];
        mul_b = LCG_MUL_LO;
      end
    endcase
  end

  assign product = STATE_W'(mul_a) * STATE_W'(mul_b);

  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    draw_d  = draw_q;
    if (cmd_i.clr_state) begin
      state_d = '0;
    end else if (cmd_i.add_seed) begin
      state_d = state_q + seed_q;
    end else begin
      unique case (cmd_i.mul_ph)
        MUL_LO: begin
          acc_d  = product + STATE_W'(1);
          draw_d = perm;
        end
        MUL_X1: begin
          acc_d[STATE_W-1:DATA_W] = acc_q[STATE_W-1:DATA_W] + product[DATA_W-1:0];
        end
        MUL_X2: begin
          state_d = {acc_q[STATE_W-1:DATA_W] + product[DATA_W-1:0], acc_q[DATA_W-1:0]};
        end
        default: begin
        end
      endcase
    end
  end

  assign span      = hi_q - lo_q + DATA_W'(1);
  assign span_zero = (span == '0);

  assign div_dividend = (cmd_i.div_sel == DIV_LIMIT) ? ALL_ONES : draw_q;

  pcg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (span),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  assign offset = span_zero ? draw_q : div_rem;

  always_comb begin
    raw_d    = '0;
    ranged_d = '0;
    unique case (cmd_i.res_status)
      ST_BAD_RANGE: ranged_d = lo_q;
      ST_OK: begin
        if (op_q == OP_RAW) begin
          raw_d = draw_q;
        end else if (op_q == OP_RANGED) begin
          ranged_d = lo_q + offset;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q  <= '0;
      state_q <= '0;
    end else begin
      if (cfg_we_i) begin
        seed_q <= cfg_data_i;
      end
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    draw_q <= draw_d;
    if (cmd_i.accept) begin
      lo_q <= in_data_i[DATA_W-1:0];
      hi_q <= in_data_i[2*DATA_W-1:DATA_W];
      op_q <= op_e'(in_user_i);
    end
    if (cmd_i.load_limit) begin
      limit_q <= ALL_ONES - div_rem;
    end
    if (cmd_i.load_result) begin
      raw_q    <= raw_d;
      ranged_q <= ranged_d;
      status_q <= cmd_i.res_status;
    end
  end

  assign sts_o.op        = op_q;
  assign sts_o.range_bad = ($signed(lo_q) > $signed(hi_q));
  assign sts_o.span_zero = span_zero;
  assign sts_o.reject    = (draw_q >= limit_q);
  assign sts_o.div_done  = div_done;

  assign out_data_o = {ranged_q, raw_q};
  assign out_user_o = status_q;

endmodule

`default_nettype wire

// ----- rtl/pcg_ctrl.sv -----
// Controller of the PCG32 generator: sequences reseeds, generator steps, divisions
// and the result handshake. Uses pcg_pkg.
`default_nettype none

module pcg_ctrl
  import pcg_pkg::*;
#(
  parameter int unsigned WARMUP_STEPS = WARMUP_STEPS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  localparam int unsigned CNT_W = $clog2(WARMUP_STEPS + 2);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WARMUP_STEPS + 1);

  fsm_e             state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             seeded_q, seeded_d;
  logic             ovalid_q, ovalid_d;
  status_e          res_q, res_d;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    seeded_d = seeded_q;
    res_d    = res_q;
    cmd_o             = '0;
    cmd_o.mul_ph      = MUL_IDLE;
    cmd_o.div_sel     = DIV_LIMIT;
    cmd_o.res_status  = res_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        res_d = ST_OK;
        unique case (sts_i.op)
          OP_RESEED: begin
            cmd_o.clr_state = 1'b1;
            seeded_d        = 1'b1;
            cnt_d           = '0;
            state_d         = S_STEP_LO;
          end
          OP_RAW: begin
            if (!seeded_q) begin
              res_d   = ST_NOT_SEEDED;
              state_d = S_DONE;
            end else begin
              state_d = S_STEP_LO;
            end
          end
          OP_RANGED: begin
            if (!seeded_q) begin
              res_d   = ST_NOT_SEEDED;
              state_d = S_DONE;
            end else if (sts_i.range_bad) begin
              res_d   = ST_BAD_RANGE;
              state_d = S_DONE;
            end else if (sts_i.span_zero) begin
              state_d = S_STEP_LO;
            end else begin
              cmd_o.div_start = 1'b1;
              cmd_o.div_sel   = DIV_LIMIT;
              state_d         = S_LIMIT_DIV;
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_LIMIT_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.load_limit = 1'b1;
          state_d          = S_STEP_LO;
        end
      end
      S_STEP_LO: begin
        cmd_o.mul_ph = MUL_LO;
        state_d      = S_STEP_X1;
      end
      S_STEP_X1: begin
        cmd_o.mul_ph = MUL_X1;
        state_d      = S_STEP_X2;
      end
      S_STEP_X2: begin
        cmd_o.mul_ph = MUL_X2;
        unique case (sts_i.op)
          OP_RESEED: begin
            if (cnt_q == '0) begin
              state_d = S_ADD_SEED;
            end else if (cnt_q == CNT_LAST) begin
              state_d = S_DONE;
            end else begin
              cnt_d   = cnt_q + 1'b1;
              state_d = S_STEP_LO;
            end
          end
          OP_RANGED: begin
            if (sts_i.span_zero) begin
              state_d = S_DONE;
            end else if (sts_i.reject) begin
              state_d = S_STEP_LO;
            end else begin
              cmd_o.div_start = 1'b1;
              cmd_o.div_sel   = DIV_DRAW;
              state_d         = S_MOD_DIV;
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_ADD_SEED: begin
        cmd_o.add_seed = 1'b1;
        cnt_d          = CNT_W'(1);
        state_d        = S_STEP_LO;
      end
      S_MOD_DIV: begin
        cmd_o.div_sel = DIV_DRAW;
        if (sts_i.div_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!ovalid_q || out_ready_i) begin
          cmd_o.load_result = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ovalid_d = ovalid_q && !out_ready_i;
    if (cmd_o.load_result) begin
      ovalid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      seeded_q <= 1'b0;
      ovalid_q <= 1'b0;
      res_q    <= ST_OK;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      seeded_q <= seeded_d;
      ovalid_q <= ovalid_d;
      res_q    <= res_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ovalid_q;

endmodule

`default_nettype wire

// ----- rtl/pcg32_random_generator_unit.sv -----
// A raw draw runs one generator step; a reseed runs WARMUP_STEPS + 2 steps, adding the seed
// after the first; a ranged draw runs a remainder pass for the limit, a step per draw until
// one is kept and a remainder pass on it; a full-range draw runs one step. One request is in
// flight at a time; the 64-bit LCG step takes three passes through one 32x32 multiplier.
// The result register lets a new request enter while the last result waits.
// Reset clears the state, the seed register and the seeded flag; draws report not seeded.
`default_nettype none

module pcg32_random_generator_unit
  import pcg_pkg::*;
#(
  parameter int unsigned WARMUP_STEPS = WARMUP_STEPS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  wire logic [2*DATA_W-1:0]   s_axis_tdata_i,  // range_low, range_high
  input  wire logic [1:0]            s_axis_tuser_i,  // opcode
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  output logic      [2*DATA_W-1:0]   m_axis_tdata_o,  // raw_word, ranged_value
  output logic      [1:0]            m_axis_tuser_o,  // status
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [STATE_W-1:0]    cfg_data_i       // seed_value
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  pcg_ctrl #(
    .WARMUP_STEPS (WARMUP_STEPS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pcg_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (s_axis_tdata_i),
    .in_user_i  (s_axis_tuser_i),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .out_data_o (m_axis_tdata_o),
    .out_user_o (m_axis_tuser_o)
  );

endmodule

`default_nettype wire

// ----- rtl/pcg_chk.sv -----
// Port-level checker for the PCG32 generator unit, bound to the top level.
// Uses pcg_pkg for status codes.
`default_nettype none

module pcg_chk
  import pcg_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tvalid_i,
  input wire logic                s_axis_tready_o,
  input wire logic                m_axis_tvalid_o,
  input wire logic                m_axis_tready_i,
  input wire logic [2*DATA_W-1:0] m_axis_tdata_o,
  input wire logic [1:0]          m_axis_tuser_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("Stalled result changed.");

  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("Request taken while another was in flight.");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      (m_axis_tuser_o == ST_OK) || (m_axis_tuser_o == ST_NOT_SEEDED) ||
      (m_axis_tuser_o == ST_BAD_RANGE))
    else $error("Unknown status code.");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != ST_OK) |-> (m_axis_tdata_o[DATA_W-1:0] == '0))
    else $error("Raw word not zero on an error result.");

endmodule

bind pcg32_random_generator_unit pcg_chk u_pcg_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire
